// ===== hw/rtl/sbfr_pkg.sv =====
package sbfr_pkg;

  localparam int FRAME_BYTES_DEF = 121;
  localparam int SLOTS_DEF       = 3;

  localparam logic [7:0] MARKER_RESET = 8'hB0;

  localparam int SLOT_W      = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [2:0] CHARS_ONE_BYTE = 3'd2;
  localparam logic [2:0] CHARS_TWO_BYTE = 3'd4;

  typedef enum logic [2:0] {
    RD_IDLE,
    RD_FETCH,
    RD_HI,
    RD_LO,
    RD_PUSH
  } sbfr_rd_state_t;

  // Readout request from the intake side
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } sbfr_start_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic logic [15:0] hex_pair(input logic [7:0] b);
    return {hex_char(b[7:4]), hex_char(b[3:0])};
  endfunction

endpackage

// ===== hw/rtl/start_byte_frame_reassembler.sv =====
// Intake: an item that completes no frame is absorbed when it is accepted; the
// last byte of a frame starts the readout, which stalls the input until done.
// Each result steps through fetch, two frame memory reads and push, a final
// odd byte through fetch, one read and push, so the input stalls for each
// frame, and also while a result is held by the output side.
// Reset (rst_n, synchronous, active low) empties all slots, sets marker 0xB0.
module start_byte_frame_reassembler import sbfr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int SLOTS       = SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] slot, [9:2] data_byte, [10] chunk_first, [15:11] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] out_slot, [33:2] hex_text, [36:34] char_count, [39:37] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int DEPTH = SLOTS * FRAME_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  sbfr_start_t   start;
  logic          busy;

  assign in_tready = !busy;
  assign accept    = in_tvalid && in_tready;

  sbfr_intake #(
    .FRAME_BYTES(FRAME_BYTES),
    .SLOTS      (SLOTS),
    .AW         (AW)
  ) u_intake (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .func       (in_tuser),
    .slot       (in_tdata[1:0]),
    .data_byte  (in_tdata[9:2]),
    .chunk_first(in_tdata[10]),
    .chunk_last (in_tlast),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .start      (start)
  );

  sbfr_frame_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  sbfr_readout #(
    .FRAME_BYTES(FRAME_BYTES),
    .SLOTS      (SLOTS),
    .AW         (AW)
  ) u_readout (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> accept)
    else $error("frame memory written without an accepted transaction");

  a_stall_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    start.valid |=> !in_tready)
    else $error("input not stalled after frame completion");

  a_odd_byte_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[36:34] == CHARS_ONE_BYTE) |-> out_tlast)
    else $error("two-character result not marked as frame end");
`endif

endmodule

// ===== hw/rtl/sbfr_frame_mem.sv =====
module sbfr_frame_mem #(
  parameter int DEPTH = 363,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/sbfr_intake.sv =====
module sbfr_intake import sbfr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int SLOTS       = SLOTS_DEF,
  parameter int AW          = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              accept,
  input  logic              func,
  input  logic [SLOT_W-1:0] slot,
  input  logic [7:0]        data_byte,
  input  logic              chunk_first,
  input  logic              chunk_last,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [7:0]        mem_wdata,
  output sbfr_start_t       start
);

  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW  = $clog2(FRAME_BYTES);

  logic [7:0]    marker_r;
  logic [FW-1:0] fill_r [SLOTS];
  logic          hunt_r [SLOTS];

  logic [31:0]    slot_ext;
  logic [SIW-1:0] si;
  logic           slot_ok;
  logic [FW-1:0]  fill_base;
  logic           hunt_base;
  logic [FW:0]    fill_inc;
  logic           drop;
  logic           done;
  logic [FW-1:0]  fill_nxt;
  logic           hunt_nxt;

  assign slot_ext = 32'(slot);
  assign si       = slot_ext[SIW-1:0];
  assign slot_ok  = slot_ext < 32'(SLOTS);

  always_comb begin
    fill_base = (chunk_first && data_byte == marker_r) ? '0 : fill_r[si];
    hunt_base = chunk_first ? 1'b0 : hunt_r[si];
    drop      = hunt_base && (data_byte != marker_r);
    fill_inc  = {1'b0, fill_base} + (FW+1)'(1);
    done      = !drop && (fill_inc == (FW+1)'(FRAME_BYTES));
    fill_nxt  = fill_base;
    hunt_nxt  = 1'b0;
    if (func) begin
      fill_nxt = '0;
      hunt_nxt = 1'b0;
    end else if (drop) begin
      hunt_nxt = !chunk_last;
    end else if (done) begin
      fill_nxt = '0;
      hunt_nxt = !chunk_last;
    end else begin
      fill_nxt = fill_inc[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
    end else if (cfg_wr_en) begin
      marker_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        fill_r[i] <= '0;
        hunt_r[i] <= 1'b0;
      end
    end else if (accept && slot_ok) begin
      fill_r[si] <= fill_nxt;
      hunt_r[si] <= hunt_nxt;
    end
  end

  assign mem_we      = accept && slot_ok && !func && !drop;
  assign mem_waddr   = AW'(AW'(si) * AW'(FRAME_BYTES)) + AW'(fill_base);
  assign mem_wdata   = data_byte;
  assign start.valid = mem_we && done;
  assign start.slot  = slot;

endmodule

// ===== hw/rtl/sbfr_readout.sv =====
module sbfr_readout import sbfr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int SLOTS       = SLOTS_DEF,
  parameter int AW          = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sbfr_start_t            start,
  output logic                   busy,
  output logic [AW-1:0]          mem_raddr,
  input  logic [7:0]             mem_rdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW  = $clog2(FRAME_BYTES);

  sbfr_rd_state_t state_r, state_nxt;
  logic [FW-1:0]     idx_r, idx_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic              pair_r, pair_nxt;
  logic              end_r, end_nxt;

  logic                   ovalid_r, ovalid_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic                   olast_r, olast_nxt;

  logic [31:0]    slot_ext;
  logic [SIW-1:0] si;
  logic [FW+1:0]  idx_ext;
  logic           load;
  logic [31:0]    text;
  logic [2:0]     count;

  assign slot_ext  = 32'(slot_r);
  assign si        = slot_ext[SIW-1:0];
  assign idx_ext   = (FW+2)'(idx_r);
  assign mem_raddr = AW'(AW'(si) * AW'(FRAME_BYTES)) + AW'(idx_r)
                   + ((state_r == RD_HI) ? AW'(1) : AW'(0));

  assign text  = {hex_pair(hi_r), pair_r ? hex_pair(lo_r) : 16'h0000};
  assign count = pair_r ? CHARS_TWO_BYTE : CHARS_ONE_BYTE;
  assign load  = (state_r == RD_PUSH) && (!ovalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    slot_nxt  = slot_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    pair_nxt  = pair_r;
    end_nxt   = end_r;
    unique case (state_r)
      RD_IDLE: begin
        if (start.valid) begin
          slot_nxt  = start.slot;
          idx_nxt   = '0;
          state_nxt = RD_FETCH;
        end
      end
      RD_FETCH: begin
        state_nxt = RD_HI;
      end
      RD_HI: begin
        hi_nxt = mem_rdata;
        if (idx_ext + (FW+2)'(1) < (FW+2)'(FRAME_BYTES)) begin
          state_nxt = RD_LO;
        end else begin
          pair_nxt  = 1'b0;
          lo_nxt    = '0;
          end_nxt   = 1'b1;
          state_nxt = RD_PUSH;
        end
      end
      RD_LO: begin
        lo_nxt    = mem_rdata;
        pair_nxt  = 1'b1;
        end_nxt   = idx_ext + (FW+2)'(2) >= (FW+2)'(FRAME_BYTES);
        state_nxt = RD_PUSH;
      end
      RD_PUSH: begin
        if (load) begin
          if (end_r) begin
            state_nxt = RD_IDLE;
          end else begin
            idx_nxt   = FW'(idx_ext + (FW+2)'(2));
            state_nxt = RD_FETCH;
          end
        end
      end
      default: begin
        state_nxt = RD_IDLE;
      end
    endcase
  end

  // Output register: hold until taken, refill in the same cycle
  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    if (load) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = {3'b000, count, text, slot_r};
      olast_nxt  = end_r;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= RD_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    slot_r  <= slot_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    pair_r  <= pair_nxt;
    end_r   <= end_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign busy       = (state_r != RD_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

// ===== verif/tb_start_byte_frame_reassembler.sv =====
`timescale 1ns / 100ps

module tb_start_byte_frame_reassembler;
  import sbfr_pkg::*;

  localparam int RANDOM_ITEMS   = 230;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [1:0]   NO_SLOT   = 2'd3;
  localparam logic [127:0] HEX_ASCII = "0123456789ABCDEF";

  typedef enum logic {
    FN_DATA       = 1'b0,
    FN_DISCONNECT = 1'b1
  } link_func_t;

  typedef struct packed {
    link_func_t  func;
    logic [1:0]  slot;
    logic [7:0]  data;
    logic        chunk_first;
    logic        chunk_last;
  } link_item_t;

  typedef struct packed {
    logic [1:0]  slot;
    logic [31:0] text;
    logic [2:0]  chars;
    logic        fend;
  } hex_word_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [7:0]             cfg_wr_data = 8'h00;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = 1'b0;
  logic                   in_tlast    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  start_byte_frame_reassembler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always #4 clk = ~clk;

  // Shadow of the block's state
  logic [7:0] marker;
  logic [7:0] frame_bytes [SLOTS_DEF][FRAME_BYTES_DEF];
  int         fill [SLOTS_DEF];
  bit         hunt [SLOTS_DEF];

  link_item_t link_items [$];
  hex_word_t  hex_words_due [$];
  link_item_t on_wire;

  int  items_pushed   = 0;
  int  items_accepted = 0;
  int  quota_items    = 0;
  int  errors         = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  int  quiet_cycles   = 0;
  bit  idle_on        = 1'b1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] hex_ascii(input logic [7:0] b);
    return {HEX_ASCII[(15 - b[7:4]) * 8 +: 8], HEX_ASCII[(15 - b[3:0]) * 8 +: 8]};
  endfunction

  // Apply one accepted item to the shadow state and queue the hex words it releases
  task automatic absorb_byte(input link_item_t it);
    int        s;
    int        k;
    hex_word_t w;
    s = int'(it.slot);
    if (s >= SLOTS_DEF) return;
    if (it.func == FN_DISCONNECT) begin
      fill[s] = 0;
      hunt[s] = 1'b0;
      return;
    end
    if (it.chunk_first) begin
      hunt[s] = 1'b0;
      if (it.data == marker) fill[s] = 0;
    end
    if (hunt[s]) begin
      if (it.data != marker) begin
        if (it.chunk_last) hunt[s] = 1'b0;
        return;
      end
      hunt[s] = 1'b0;
    end
    if (fill[s] < FRAME_BYTES_DEF) begin
      frame_bytes[s][fill[s]] = it.data;
      fill[s]++;
    end
    if (fill[s] >= FRAME_BYTES_DEF) begin
      for (k = 0; k < FRAME_BYTES_DEF; k += 2) begin
        w.slot  = s[1:0];
        w.text  = {hex_ascii(frame_bytes[s][k]), 16'h0000};
        w.chars = CHARS_ONE_BYTE;
        if (k + 1 < FRAME_BYTES_DEF) begin
          w.text[15:0] = hex_ascii(frame_bytes[s][k + 1]);
          w.chars      = CHARS_TWO_BYTE;
        end
        w.fend = (k + 2 >= FRAME_BYTES_DEF);
        hex_words_due = {hex_words_due, w};
      end
      fill[s] = 0;
      hunt[s] = !it.chunk_last;
    end else if (it.chunk_last) begin
      hunt[s] = 1'b0;
    end
  endtask

  // Sender: advance to the next pending item once the current transaction completes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        absorb_byte(on_wire);
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || link_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          on_wire = link_items.pop_front();
          in_tdata  <= {5'd0, on_wire.chunk_first, on_wire.data, on_wire.slot};
          in_tuser  <= on_wire.func;
          in_tlast  <= on_wire.chunk_last;
          in_tvalid <= 1'b1;
          gap_left = pick_gap();
        end
      end
    end
  end

  // Receiver: check each hex word against the oldest expectation
  always @(posedge clk) begin
    hex_word_t got;
    hex_word_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.slot  = out_tdata[1:0];
        got.text  = out_tdata[33:2];
        got.chars = out_tdata[36:34];
        got.fend  = out_tlast;
        if (hex_words_due.size() == 0) begin
          errors++;
          $display("%0t: hex word with none expected: slot %0d text %h chars %0d end %0b",
                   $time, got.slot, got.text, got.chars, got.fend);
        end else begin
          want = hex_words_due.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected slot %0d text %h chars %0d end %0b", $time,
                     want.slot, want.text, want.chars, want.fend);
            $display("%0t: actual   slot %0d text %h chars %0d end %0b", $time,
                     got.slot, got.text, got.chars, got.fend);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_start_byte_frame_reassembler failed");
      $finish;
    end
  end

  task automatic push_item(input link_func_t f, input logic [1:0] s, input logic [7:0] d,
                           input logic cf, input logic cl);
    link_item_t it;
    it.func        = f;
    it.slot        = s;
    it.data        = d;
    it.chunk_first = cf;
    it.chunk_last  = cl;
    link_items = {link_items, it};
    items_pushed++;
    if (s != NO_SLOT) quota_items++;
  endtask

  // Hold until every item is taken and every hex word has come back
  task automatic wait_drained();
    while (items_accepted != items_pushed || hex_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_marker(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    marker = v;
  endtask

  // Interleave traffic that is ignored, belongs to other slots or disconnects this slot
  task automatic push_noise(input int s);
    int         r;
    int         k;
    int         len;
    logic [1:0] other;
    r     = $urandom_range(0, 9);
    other = 2'((s + $urandom_range(1, SLOTS_DEF - 1)) % SLOTS_DEF);
    if (r < 2) begin
      push_item(link_func_t'($urandom_range(0, 1)), NO_SLOT, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (r < 4) begin
      push_item(FN_DISCONNECT, other, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (r < 5) begin
      push_item(FN_DISCONNECT, s[1:0], 8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      len = $urandom_range(1, 3);
      for (k = 0; k < len; k++) begin
        push_item(FN_DATA, other,
                  (k == 0 && $urandom_range(0, 1)) ? marker : 8'($urandom_range(0, 255)),
                  k == 0, k == len - 1);
      end
    end
  endtask

  // One frame, at times with up to eight trailing bytes, sent as a marker-led chunk followed by continuation chunks
  task automatic send_frame(input int s);
    int         total;
    int         sent;
    int         len;
    int         k;
    bit         ends_clean;
    logic [7:0] d;
    total = FRAME_BYTES_DEF + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
    sent  = 0;
    while (sent < total) begin
      len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
      if (len > total - sent) len = total - sent;
      ends_clean = ($urandom_range(0, 14) != 0);
      for (k = 0; k < len; k++) begin
        if (sent == 0 && k == 0) begin
          d = marker;
        end else if (k == 0) begin
          d = 8'($urandom_range(0, 255));
          if (d == marker) d = d ^ 8'h01;
        end else begin
          d = ($urandom_range(0, 11) == 0) ? marker : 8'($urandom_range(0, 255));
        end
        push_item(FN_DATA, s[1:0], d, k == 0, (k == len - 1) && ends_clean);
      end
      sent += len;
      if ($urandom_range(0, 4) == 0) push_noise(s);
    end
  endtask

  initial begin
    int phase;
    marker = MARKER_RESET;
    for (int s = 0; s < SLOTS_DEF; s++) begin
      fill[s] = 0;
      hunt[s] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ignored slot, marker restarts, unterminated chunk, disconnects
    push_item(FN_DATA,       NO_SLOT, 8'hFF, 1'b1, 1'b1);
    push_item(FN_DISCONNECT, NO_SLOT, 8'h00, 1'b0, 1'b0);
    push_item(FN_DATA,       2'd0,    MARKER_RESET, 1'b1, 1'b0);
    push_item(FN_DATA,       2'd0,    8'h00, 1'b0, 1'b0);
    push_item(FN_DATA,       2'd0,    8'hFF, 1'b0, 1'b1);
    push_item(FN_DATA,       2'd1,    8'hFF, 1'b1, 1'b1);
    push_item(FN_DATA,       2'd2,    8'h12, 1'b1, 1'b0);
    push_item(FN_DATA,       2'd2,    8'hA5, 1'b0, 1'b0);
    push_item(FN_DATA,       2'd2,    MARKER_RESET, 1'b1, 1'b0);
    push_item(FN_DATA,       2'd2,    8'h5A, 1'b0, 1'b1);
    push_item(FN_DISCONNECT, 2'd0,    8'hFF, 1'b1, 1'b1);
    push_item(FN_DATA,       2'd0,    8'h00, 1'b1, 1'b1);
    push_item(FN_DATA,       2'd1,    MARKER_RESET, 1'b0, 1'b0);
    push_item(FN_DISCONNECT, 2'd1,    8'h3C, 1'b0, 1'b0);
    push_item(FN_DATA,       2'd1,    8'hC3, 1'b0, 1'b1);
    push_item(FN_DATA,       NO_SLOT, MARKER_RESET, 1'b0, 1'b0);
    wait_drained();
    quota_items = 0;

    phase = 0;
    while (quota_items < RANDOM_ITEMS && phase < 40) begin
      case (phase % 4)
        0: begin
          set_marker(8'h00);
        end
        1: begin
          set_marker(8'hFF);
        end
        2: begin
          set_marker(8'($urandom_range(1, 254)));
        end
        default: begin
          set_marker(MARKER_RESET);
        end
      endcase
      idle_on = (phase % 3 != 2);
      send_frame($urandom_range(0, SLOTS_DEF - 1));
      wait_drained();
      phase++;
    end

    if (errors == 0) begin
      $display("tb_start_byte_frame_reassembler passed");
    end else begin
      $display("tb_start_byte_frame_reassembler failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sbfr_pkg.sv
hw/rtl/sbfr_frame_mem.sv
hw/rtl/sbfr_intake.sv
hw/rtl/sbfr_readout.sv
hw/rtl/start_byte_frame_reassembler.sv
verif/tb_start_byte_frame_reassembler.sv
